### sv/mm2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2a_pkg
// Shared types and constants of the MurmurHash2A byte-stream hasher.
// ----------------------------------------------------------------------------
package mm2a_pkg;

    localparam int unsigned HashWidth = 32;
    localparam int unsigned HeldWidth = 24;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned PhaseWidth = 2;

    localparam logic [HashWidth-1:0] MixMul = 32'h5bd1_e995;
    localparam int unsigned MixShift = 24;
    localparam int unsigned FinShiftA = 13;
    localparam int unsigned FinShiftB = 15;

    localparam logic [PhaseWidth-1:0] PhaseLast = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_K1,
        ST_MIX_K2,
        ST_MIX_H,
        ST_FIN_TAIL,
        ST_FIN_LEN,
        ST_FIN_XS,
        ST_FIN_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_WORD,
        SEL_TAIL,
        SEL_LEN
    } mix_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SEED,
        OP_ACCEPT,
        OP_MUL_K,
        OP_MUL_KX,
        OP_MIX_HASH,
        OP_MIX_WORK,
        OP_LOAD_TAIL,
        OP_LOAD_LEN,
        OP_FIN_MUL,
        OP_FIN_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic word_full;
        logic out_busy;
    } dp_status_t;

endpackage

### sv/murmur2a_hash_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2a_hash_stream_unit
// 32-bit MurmurHash2A of a key streamed in one byte per transaction.
// ----------------------------------------------------------------------------
// Input channel (s_*): one transaction carries an optional key byte
// (s_has_byte) and an end-of-key flag (s_is_last). Output channel (m_*):
// one transaction with the finished hash per key. The seed is written
// through the cfg_* channel while the block is idle; a write restarts the
// key in progress. A write and a byte offered together: the write wins.
// A byte that does not complete a 4-byte word is taken while the block stays
// idle. The fourth byte of a word starts the word mix, which runs three
// multiplies in turn through the single shared 32x32 multiplier; no byte is
// taken until it ends. The ending transaction then starts the finalization:
// the controller walks the tail mix, the length mix and the final multiply
// on that multiplier before the hash appears in the output register.
// The output register frees the input side: the next key streams in while
// the hash waits. If a second hash is ready while the first is still held,
// the block stalls until the receiver takes the first.
// Reset (aresetn low, synchronous) clears the seed to zero, drops any key in
// progress and empties the output register.
// ----------------------------------------------------------------------------
module murmur2a_hash_stream_unit
    import mm2a_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ByteWidth-1:0] s_data_byte,
    input  logic                 s_has_byte,
    input  logic                 s_is_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [HashWidth-1:0] m_hash_value,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [HashWidth-1:0] cfg_seed
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mm2a_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_has_byte (s_has_byte),
        .s_is_last  (s_is_last),
        .cfg_valid  (cfg_valid),
        .status     (status),
        .s_ready    (s_ready),
        .cfg_ready  (cfg_ready),
        .cmd        (cmd)
    );

    mm2a_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_data_byte  (s_data_byte),
        .s_has_byte   (s_has_byte),
        .cfg_seed     (cfg_seed),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_hash_value (m_hash_value),
        .status       (status)
    );

endmodule

### sv/mm2a_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2a_ctrl
// Sequencer that steps the shared multiplier through word mixing and the
// finalization of each key.
// ----------------------------------------------------------------------------
module mm2a_ctrl
    import mm2a_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_has_byte,
    input  logic       s_is_last,
    input  logic       cfg_valid,
    input  dp_status_t status,
    output logic       s_ready,
    output logic       cfg_ready,
    output dp_cmd_t    cmd
);

    state_t   state_reg, state_next;
    mix_sel_t sel_reg, sel_next;
    logic     last_pend_reg, last_pend_next;
    logic     in_fire;

    assign in_fire = (state_reg == ST_IDLE) && !cfg_valid && s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_WORD;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            last_pend_reg <= last_pend_next;
        end
    end

    // Next state.
    always_comb begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        last_pend_next = last_pend_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    last_pend_next = s_is_last;
                    if (s_has_byte && status.word_full) begin
                        sel_next   = SEL_WORD;
                        state_next = ST_MIX_K1;
                    end else if (s_is_last) begin
                        state_next = ST_FIN_TAIL;
                    end
                end
            end
            ST_MIX_K1: state_next = ST_MIX_K2;
            ST_MIX_K2: state_next = ST_MIX_H;
            ST_MIX_H: begin
                unique case (sel_reg)
                    SEL_WORD: state_next = last_pend_reg ? ST_FIN_TAIL : ST_IDLE;
                    SEL_TAIL: state_next = ST_FIN_LEN;
                    SEL_LEN:  state_next = ST_FIN_XS;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_FIN_TAIL: begin
                sel_next   = SEL_TAIL;
                state_next = ST_MIX_K1;
            end
            ST_FIN_LEN: begin
                sel_next   = SEL_LEN;
                state_next = ST_MIX_K1;
            end
            ST_FIN_XS: state_next = ST_FIN_OUT;
            ST_FIN_OUT: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        cmd.op    = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                if (cfg_valid) begin
                    cmd.op = OP_SEED;
                end else if (s_valid) begin
                    cmd.op = OP_ACCEPT;
                end
            end
            ST_MIX_K1:   cmd.op = OP_MUL_K;
            ST_MIX_K2:   cmd.op = OP_MUL_KX;
            ST_MIX_H:    cmd.op = (sel_reg == SEL_WORD) ? OP_MIX_HASH : OP_MIX_WORK;
            ST_FIN_TAIL: cmd.op = OP_LOAD_TAIL;
            ST_FIN_LEN:  cmd.op = OP_LOAD_LEN;
            ST_FIN_XS:   cmd.op = OP_FIN_MUL;
            ST_FIN_OUT:  cmd.op = status.out_busy ? OP_NONE : OP_FIN_OUT;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

### sv/mm2a_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2a_datapath
// Hash state, byte packing, one shared 32x32 multiplier and the output
// register.
// ----------------------------------------------------------------------------
module mm2a_datapath
    import mm2a_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    input  logic [ByteWidth-1:0] s_data_byte,
    input  logic                 s_has_byte,
    input  logic [HashWidth-1:0] cfg_seed,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [HashWidth-1:0] m_hash_value,
    output dp_status_t           status
);

    logic [HashWidth-1:0]  seed_reg, seed_next;
    logic [HashWidth-1:0]  hash_reg, hash_next;
    logic [HeldWidth-1:0]  held_reg, held_next;
    logic [PhaseWidth-1:0] phase_reg, phase_next;
    logic [HashWidth-1:0]  len_reg, len_next;
    logic [HashWidth-1:0]  k_reg, k_next;
    logic [HashWidth-1:0]  work_reg, work_next;
    logic [HashWidth-1:0]  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [HashWidth-1:0]  mul_a;
    logic [HashWidth-1:0]  product;

    // Shared multiplier; the product is kept modulo 2^32.
    always_comb begin
        unique case (cmd.op)
            OP_MUL_KX:   mul_a = k_reg ^ (k_reg >> MixShift);
            OP_MIX_HASH: mul_a = hash_reg;
            OP_MIX_WORK: mul_a = work_reg;
            OP_FIN_MUL:  mul_a = work_reg ^ (work_reg >> FinShiftA);
            default:     mul_a = k_reg;
        endcase
    end

    assign product = mul_a * MixMul;

    always_comb begin
        seed_next      = seed_reg;
        hash_next      = hash_reg;
        held_next      = held_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        work_next      = work_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (cmd.op)
            OP_SEED: begin
                seed_next  = cfg_seed;
                hash_next  = cfg_seed;
                held_next  = '0;
                phase_next = '0;
                len_next   = '0;
            end
            OP_ACCEPT: begin
                if (s_has_byte) begin
                    len_next = len_reg + HashWidth'(1);
                    if (phase_reg == PhaseLast) begin
                        k_next     = {s_data_byte, held_reg};
                        held_next  = '0;
                        phase_next = '0;
                    end else begin
                        unique case (phase_reg)
                            2'd0:    held_next[7:0]   = s_data_byte;
                            2'd1:    held_next[15:8]  = s_data_byte;
                            default: held_next[23:16] = s_data_byte;
                        endcase
                        phase_next = phase_reg + PhaseWidth'(1);
                    end
                end
            end
            OP_MUL_K:     k_next = product;
            OP_MUL_KX:    k_next = product;
            OP_MIX_HASH:  hash_next = product ^ k_reg;
            OP_MIX_WORK:  work_next = product ^ k_reg;
            OP_LOAD_TAIL: begin
                k_next    = {{(HashWidth-HeldWidth){1'b0}}, held_reg};
                work_next = hash_reg;
            end
            OP_LOAD_LEN:  k_next = len_reg;
            OP_FIN_MUL:   work_next = product;
            OP_FIN_OUT: begin
                out_next       = work_reg ^ (work_reg >> FinShiftB);
                out_valid_next = 1'b1;
                hash_next      = seed_reg;
                held_next      = '0;
                phase_next     = '0;
                len_next       = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            hash_reg      <= '0;
            held_reg      <= '0;
            phase_reg     <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            seed_reg      <= seed_next;
            hash_reg      <= hash_next;
            held_reg      <= held_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg    <= k_next;
        work_reg <= work_next;
        out_reg  <= out_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_hash_value     = out_reg;
    assign status.word_full = (phase_reg == PhaseLast);
    assign status.out_busy  = out_valid_reg && !m_ready;

endmodule

### sv/mm2a_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm2a_checker
// Port-level checks of the hasher, bound to the top level.
// ----------------------------------------------------------------------------
module mm2a_checker
    import mm2a_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_is_last,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [HashWidth-1:0] m_hash_value,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    // A held result keeps its value until the receiver takes it.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value))
        else $error("result changed or dropped while stalled");

    // Finalization occupies the block right after an ending transaction.
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_is_last |=> !s_ready && !cfg_ready)
        else $error("block ready during finalization");

    // A seed write and a byte never land in the same cycle.
    a_cfg_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |-> !(s_valid && s_ready))
        else $error("seed write and input transaction together");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind murmur2a_hash_stream_unit mm2a_checker u_mm2a_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_is_last    (s_is_last),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hash_value (m_hash_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

### tb/sv/murmur2a_hash_stream_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2a_hash_stream_unit_tb
// Self-checking testbench for the streaming MurmurHash2A hasher.
// ----------------------------------------------------------------------------
// Keys are streamed in one byte per transaction. A scoreboard class predicts
// the hash of every finished key and compares it with each transaction on the
// result channel. A directed run covers the empty key, idle items, tails of
// one to three bytes, a word that completes on the ending byte, extreme byte
// and seed values and a seed write that drops a key in progress. Random phases
// with different seeds follow, with random gaps on both, one or no channel,
// and one long receiver hold-off that makes the block stall its input.
// ----------------------------------------------------------------------------
module murmur2a_hash_stream_unit_tb;
    import mm2a_pkg::*;

    class hash_scoreboard;
        logic [HashWidth-1:0]  seed;
        logic [HashWidth-1:0]  running;
        logic [HeldWidth-1:0]  held;
        logic [PhaseWidth-1:0] phase;
        logic [HashWidth-1:0]  key_len;
        logic [HashWidth-1:0]  hash_want[$];
        int                    mismatches;

        function new();
            seed = '0;
            mismatches = 0;
            restart_key();
        endfunction

        function void restart_key();
            running = seed;
            held = '0;
            phase = '0;
            key_len = '0;
        endfunction

        function void load_seed(logic [HashWidth-1:0] value);
            seed = value;
            restart_key();
        endfunction

        function logic [HashWidth-1:0] mix_word(logic [HashWidth-1:0] h,
                                                logic [HashWidth-1:0] k);
            k = k * MixMul;
            k = k ^ (k >> MixShift);
            k = k * MixMul;
            return (h * MixMul) ^ k;
        endfunction

        function void note_input(logic [ByteWidth-1:0] b, logic has_byte, logic last);
            logic [HashWidth-1:0] h;
            if (has_byte) begin
                key_len = key_len + 1;
                if (phase == PhaseLast) begin
                    running = mix_word(running, {b, held});
                    held = '0;
                    phase = '0;
                end else begin
                    held = held | (HeldWidth'(b) << (8 * phase));
                    phase = phase + 1'b1;
                end
            end
            if (last) begin
                h = mix_word(running, {8'h00, held});
                h = mix_word(h, key_len);
                h = h ^ (h >> FinShiftA);
                h = h * MixMul;
                h = h ^ (h >> FinShiftB);
                hash_want.push_back(h);
                restart_key();
            end
        endfunction

        function void check_hash(logic [HashWidth-1:0] actual);
            logic [HashWidth-1:0] want;
            if (hash_want.size() == 0) begin
                $error("hash_value: no hash outstanding, actual %08h", actual);
                mismatches++;
            end else begin
                want = hash_want.pop_front();
                if (actual !== want) begin
                    $error("hash_value mismatch: expected %08h, actual %08h", want, actual);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return hash_want.size();
        endfunction
    endclass

    localparam int LongHold     = 400;
    localparam int SettleCycles = 20;
    localparam int PhaseItems   = 100;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [ByteWidth-1:0] s_data_byte;
    logic                 s_has_byte;
    logic                 s_is_last;
    logic                 m_valid;
    logic                 m_ready;
    logic [HashWidth-1:0] m_hash_value;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [HashWidth-1:0] cfg_seed;

    hash_scoreboard sb = new();

    bit tx_idle;
    bit rx_random;
    bit long_hold_req;
    int tx_count;

    murmur2a_hash_stream_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_has_byte   (s_has_byte),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_seed     (cfg_seed)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly back-to-back, sometimes a short gap, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.load_seed(cfg_seed);
            if (s_valid && s_ready) sb.note_input(s_data_byte, s_has_byte, s_is_last);
            if (m_valid && m_ready) sb.check_hash(m_hash_value);
        end
    end

    // Result receiver. The long hold-off is counted here so that the sender
    // keeps offering transactions while the output side is blocked.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LongHold) @(negedge aclk);
                long_hold_req = 1'b0;
            end else begin
                gap = rx_random ? pick_gap() : 0;
                if (gap == 0) begin
                    m_ready <= 1'b1;
                    @(negedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
        end
    end

    task automatic send_item(input logic [ByteWidth-1:0] b, input logic has_byte,
                             input logic last);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_has_byte  <= has_byte;
        s_is_last   <= last;
        do @(posedge aclk); while (!s_ready);
        tx_count++;
    endtask

    // A key of len bytes, ended either on its last byte or by an empty ending
    // transaction. Random keys get an occasional idle item mixed in.
    task automatic send_key(input int len, input bit empty_end, input bit rand_bytes,
                            input logic [ByteWidth-1:0] fill);
        for (int i = 0; i < len; i++) begin
            if (rand_bytes && $urandom_range(0, 9) == 0)
                send_item(ByteWidth'($urandom), 1'b0, 1'b0);
            send_item(rand_bytes ? ByteWidth'($urandom) : fill, 1'b1,
                      !empty_end && (i == len - 1));
        end
        if (empty_end || len == 0) send_item(ByteWidth'($urandom), 1'b0, 1'b1);
    endtask

    // Drop valid, let every outstanding hash arrive and give the block time
    // to finish a word mix that produces no result.
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    task automatic write_seed(input logic [HashWidth-1:0] value);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_seed  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int items);
        int r;
        int target;
        target = tx_count + items;
        while (tx_count < target) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                send_item(ByteWidth'($urandom), 1'b0, 1'b0);
            end else if (r < 17) begin
                send_key($urandom_range(0, 12), $urandom_range(0, 9) < 3, 1'b1, '0);
            end else begin
                send_key($urandom_range(13, 40), $urandom_range(0, 9) < 3, 1'b1, '0);
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = '0;
        s_has_byte    = 1'b0;
        s_is_last     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_seed      = '0;
        tx_idle       = 1'b1;
        rx_random     = 1'b1;
        long_hold_req = 1'b0;
        tx_count      = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, first with the reset seed of zero.
        send_key(0, 1'b1, 1'b0, '0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_key(1, 1'b0, 1'b0, 8'h00);
        send_key(1, 1'b0, 1'b0, 8'hFF);
        send_key(3, 1'b1, 1'b0, 8'hFF);
        send_key(4, 1'b0, 1'b0, 8'hFF);
        send_key(4, 1'b1, 1'b0, 8'h5A);
        send_key(6, 1'b0, 1'b1, '0);
        write_seed(32'hFFFF_FFFF);
        send_key(0, 1'b1, 1'b0, '0);
        send_key(2, 1'b0, 1'b0, 8'h00);
        // A seed write in the middle of a key drops the bytes taken so far.
        send_item(8'h3C, 1'b1, 1'b0);
        send_item(8'hC3, 1'b1, 1'b0);
        write_seed($urandom);
        send_key(1, 1'b0, 1'b0, 8'h81);

        write_seed($urandom);
        random_phase(PhaseItems);

        write_seed(32'hFFFF_FFFF);
        long_hold_req = 1'b1;
        random_phase(PhaseItems);

        write_seed(32'h0000_0000);
        tx_idle   = 1'b0;
        rx_random = 1'b0;
        random_phase(PhaseItems);

        write_seed($urandom);
        tx_idle = 1'b1;
        random_phase(PhaseItems);

        write_seed($urandom);
        rx_random = 1'b1;
        random_phase(PhaseItems);

        quiesce();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
